FILE: rtl/assert_macros.svh
// assertion macros shared by the texture sampler modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tns_pkg.sv
// shared types and constants of the nearest-neighbor texture sampler
// used by every module of the block; depends on nothing
package tns_pkg;

	// texture store geometry
	localparam int TEXELS = 65536;
	localparam int ADDR_W = $clog2(TEXELS);

	// field widths
	localparam int SIZE_W = 9;
	localparam int FRAC_W = 16;
	localparam int CHAN_W = 8;
	localparam int TEXEL_W = 4 * CHAN_W;
	localparam int DEST_W = 20;
	localparam int INDEX_W = 16;
	localparam int LIN_W = 2 * SIZE_W + 1;

	// decoupling queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [1:0] {
		REG_TEX_WIDTH  = 2'd0,
		REG_TEX_HEIGHT = 2'd1,
		REG_HAS_ALPHA  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		KIND_LOAD   = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	typedef struct packed {
		logic [SIZE_W-1:0] tex_width;
		logic [SIZE_W-1:0] tex_height;
		logic              has_alpha;
	} cfg_t;

	// one classified item on its way from front to back
	typedef struct packed {
		kind_t              kind;
		logic               load_ok;
		logic [ADDR_W-1:0]  addr;
		logic [TEXEL_W-1:0] texel;
		logic [DEST_W-1:0]  dest;
	} item_t;

endpackage

FILE: rtl/tns_regs.sv
// configuration register file behind the apb port
// depends on tns_pkg
module tns_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	output tns_pkg::cfg_t            cfg
);

	tns_pkg::cfg_t    cfg_q;
	tns_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx = tns_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tex_width  <= tns_pkg::SIZE_W'(1);
			cfg_q.tex_height <= tns_pkg::SIZE_W'(1);
			cfg_q.has_alpha  <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				tns_pkg::REG_TEX_WIDTH:  cfg_q.tex_width  <= pwdata[tns_pkg::SIZE_W-1:0];
				tns_pkg::REG_TEX_HEIGHT: cfg_q.tex_height <= pwdata[tns_pkg::SIZE_W-1:0];
				tns_pkg::REG_HAS_ALPHA:  cfg_q.has_alpha  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			tns_pkg::REG_TEX_WIDTH:  prdata = 32'(cfg_q.tex_width);
			tns_pkg::REG_TEX_HEIGHT: prdata = 32'(cfg_q.tex_height);
			tns_pkg::REG_HAS_ALPHA:  prdata = 32'(cfg_q.has_alpha);
			default:                 prdata = '0;
		endcase
	end

endmodule

FILE: rtl/tns_front.sv
// front end: accepts stream items, packs loads and maps sample coordinates
// to a store address over two stages; depends on tns_pkg
`include "assert_macros.svh"
module tns_front (
	input  logic                clk,
	input  logic                arst_n,
	input  tns_pkg::cfg_t       cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [135:0]        s_tdata,
	input  logic                s_tuser,
	output logic                out_valid,
	input  logic                out_ready,
	output tns_pkg::item_t      out_item
);

	function automatic logic [tns_pkg::SIZE_W-1:0] span(input logic [tns_pkg::SIZE_W-1:0] size);
		span = (size == '0) ? '0 : size - tns_pkg::SIZE_W'(1);
	endfunction

	localparam int PROD_W = tns_pkg::FRAC_W + tns_pkg::SIZE_W;

	logic                          en;
	logic                          v_s1, v_s2;
	tns_pkg::kind_t                kind_s1;
	logic                          load_ok_s1;
	logic [tns_pkg::INDEX_W-1:0]   index_s1;
	logic [tns_pkg::TEXEL_W-1:0]   texel_s1;
	logic [tns_pkg::DEST_W-1:0]    dest_s1;
	logic [tns_pkg::SIZE_W-1:0]    x_s1, y_s1;
	tns_pkg::item_t                item_s2;

	logic [tns_pkg::FRAC_W-1:0]    frac_s, frac_t;
	logic [PROD_W-1:0]             prod_s, prod_t;
	logic [tns_pkg::CHAN_W-1:0]    alpha_in;
	logic [tns_pkg::LIN_W-1:0]     lin;

	// whole front moves together when the queue can take the last stage
	assign en = !v_s2 || out_ready;
	assign s_tready = en;

	// stage 1: coordinate scaling
	assign frac_s = s_tdata[63:48];
	assign frac_t = s_tdata[95:80];
	assign prod_s = PROD_W'(frac_s) * PROD_W'(span(cfg.tex_width));
	assign prod_t = PROD_W'(frac_t) * PROD_W'(span(cfg.tex_height));
	assign alpha_in = cfg.has_alpha ? s_tdata[47:40] : tns_pkg::ALPHA_OPAQUE;

	// stage 2: linear address
	assign lin = tns_pkg::LIN_W'(x_s1) + tns_pkg::LIN_W'(y_s1) * tns_pkg::LIN_W'(cfg.tex_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	// payload of both stages
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1    <= tns_pkg::kind_t'(s_tuser);
			load_ok_s1 <= (17'(s_tdata[15:0]) < 17'(tns_pkg::TEXELS));
			index_s1   <= s_tdata[15:0];
			texel_s1   <= {alpha_in, s_tdata[39:16]};
			dest_s1    <= s_tdata[131:112];
			x_s1       <= prod_s[PROD_W-1:tns_pkg::FRAC_W];
			y_s1       <= prod_t[PROD_W-1:tns_pkg::FRAC_W];

			item_s2.kind    <= kind_s1;
			item_s2.load_ok <= load_ok_s1;
			item_s2.texel   <= texel_s1;
			item_s2.dest    <= dest_s1;
			if (kind_s1 == tns_pkg::KIND_LOAD) begin
				item_s2.addr <= index_s1[tns_pkg::ADDR_W-1:0];
			end else begin
				item_s2.addr <= lin[tns_pkg::ADDR_W-1:0];
			end
		end
	end

	assign out_valid = v_s2;
	assign out_item = item_s2;

	// a stalled last stage keeps its item
	`ASSERT_NEXT(a_front_hold, v_s2 && !out_ready, v_s2 && $stable(item_s2), "front item changed while stalled")

endmodule

FILE: rtl/tns_fifo.sv
// short queue that decouples the front end from the store access
// depends on tns_pkg
`include "assert_macros.svh"
module tns_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tns_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output tns_pkg::item_t out_item
);

	tns_pkg::item_t                 mem_q [tns_pkg::FIFO_DEPTH];
	logic [tns_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tns_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                           push, pop;

	assign in_ready = (cnt_q != tns_pkg::FIFO_CNT_W'(tns_pkg::FIFO_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_item = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + tns_pkg::FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tns_pkg::FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + tns_pkg::FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - tns_pkg::FIFO_CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	`ASSERT_ALWAYS(a_fifo_cnt_range, cnt_q <= tns_pkg::FIFO_CNT_W'(tns_pkg::FIFO_DEPTH), "fifo count out of range")
	`ASSERT_NEXT(a_fifo_cnt_up, push && !pop, cnt_q == $past(cnt_q) + tns_pkg::FIFO_CNT_W'(1), "fifo count did not grow on push")

endmodule

FILE: rtl/tns_back.sv
// back end: texel store writes for loads, registered reads for samples,
// and the result register; depends on tns_pkg
`include "assert_macros.svh"
module tns_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tns_pkg::item_t in_item,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [55:0]    m_tdata,
	output logic           m_tuser
);

	logic [tns_pkg::TEXEL_W-1:0] store [tns_pkg::TEXELS];

	logic                        en, pop;
	logic                        v_s2;
	logic [tns_pkg::TEXEL_W-1:0] rdata_s2;
	logic [tns_pkg::DEST_W-1:0]  dest_s2;
	logic                        opaque;
	logic [tns_pkg::TEXEL_W-1:0] color;

	// advance when the result register is free or being drained
	assign en = !v_s2 || m_tready;
	assign in_ready = en;
	assign pop = en && in_valid;

	// texel store: one write port and one registered read port
	always_ff @(posedge clk) begin
		if (pop && in_item.kind == tns_pkg::KIND_LOAD && in_item.load_ok) begin
			store[in_item.addr] <= in_item.texel;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rdata_s2 <= store[in_item.addr];
			dest_s2  <= in_item.dest;
		end
	end

	// result valid for samples only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= pop && (in_item.kind == tns_pkg::KIND_SAMPLE);
		end
	end

	// transparent texels read out as zero
	assign opaque = (rdata_s2[31:24] != '0);
	assign color = opaque ? rdata_s2 : '0;

	assign m_tvalid = v_s2;
	assign m_tdata = {4'b0, color, dest_s2};
	assign m_tuser = opaque;

	`ASSERT_NEXT(a_back_hold, v_s2 && !m_tready, v_s2 && $stable(rdata_s2) && $stable(dest_s2), "result changed while stalled")

endmodule

FILE: rtl/texture_nearest_sampler_core.sv
// channel     | dir | handshake         | payload
// s (items)   | in  | s_tvalid/s_tready | s_tdata, s_tuser = kind
// m (results) | out | m_tvalid/m_tready | m_tdata, m_tuser = written
// apb config  | in  | psel/penable      | paddr, pwdata, prdata, pready
//
// one item per cycle sustained while results are taken; a sample result passes through
// both front stages, a queue entry and the registered store read
// the texel store has one write and one read port, each used at most once per item
// asynchronous reset clears control only; the store holds nothing valid until loaded
// the four-entry queue lets the front keep accepting while results stall
// top level of the nearest-neighbor texture sampler; depends on tns_pkg,
// tns_regs, tns_front, tns_fifo and tns_back
module texture_nearest_sampler_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// texel_index[15:0] red[23:16] green[31:24] blue[39:32] alpha[47:40]
	// coord_s[79:48] coord_t[111:80] dest_index[131:112], zero pad
	input  logic [135:0] s_tdata,
	// kind[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_dest_index[19:0] out_red[27:20] out_green[35:28] out_blue[43:36]
	// out_alpha[51:44], zero pad
	output logic [55:0]  m_tdata,
	// written[0]
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	tns_pkg::cfg_t  cfg;
	logic           fr_valid, fr_ready;
	tns_pkg::item_t fr_item;
	logic           bk_valid, bk_ready;
	tns_pkg::item_t bk_item;

	tns_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	tns_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (fr_item),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_item  (bk_item)
	);

	tns_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bk_valid),
		.in_ready (bk_ready),
		.in_item  (bk_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: sim/texture_nearest_sampler_core_tb.sv
// self-checking testbench for texture_nearest_sampler_core: streams texel loads and
// samples under several texture sizes and checks every result against a predictor
// depends on tns_pkg and the rtl of the sampler
module texture_nearest_sampler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 12;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int PROD_W        = tns_pkg::FRAC_W + tns_pkg::SIZE_W;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// predicted texture store, register copy and queue of expected pixels
	class sample_scoreboard;
		typedef struct {
			logic [tns_pkg::DEST_W-1:0] dest;
			logic [tns_pkg::CHAN_W-1:0] red;
			logic [tns_pkg::CHAN_W-1:0] green;
			logic [tns_pkg::CHAN_W-1:0] blue;
			logic [tns_pkg::CHAN_W-1:0] alpha;
			logic                       written;
		} pixel_t;

		pixel_t                      expected_pixels[$];
		logic [tns_pkg::TEXEL_W-1:0] texels [tns_pkg::TEXELS];
		logic [tns_pkg::SIZE_W-1:0]  tex_width;
		logic [tns_pkg::SIZE_W-1:0]  tex_height;
		logic                        has_alpha;
		int                          errors;

		function new();
			tex_width = tns_pkg::SIZE_W'(1);
			tex_height = tns_pkg::SIZE_W'(1);
			has_alpha = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				tns_pkg::REG_TEX_WIDTH: tex_width = value[tns_pkg::SIZE_W-1:0];
				tns_pkg::REG_TEX_HEIGHT: tex_height = value[tns_pkg::SIZE_W-1:0];
				tns_pkg::REG_HAS_ALPHA: has_alpha = value[0];
				default: ;
			endcase
		endfunction

		// scale factor of one axis, a zero size scales by zero
		function int span_of(logic [tns_pkg::SIZE_W-1:0] size);
			return (size == 0) ? 0 : int'(size) - 1;
		endfunction

		// repeat wrap keeps the fraction, then truncating scale and linear address
		function logic [tns_pkg::ADDR_W-1:0] sample_addr(logic [31:0] s, logic [31:0] t);
			logic [tns_pkg::SIZE_W-1:0] span_s;
			logic [tns_pkg::SIZE_W-1:0] span_t;
			logic [PROD_W-1:0]          prod_s;
			logic [PROD_W-1:0]          prod_t;
			logic [tns_pkg::SIZE_W-1:0] x;
			logic [tns_pkg::SIZE_W-1:0] y;
			logic [tns_pkg::LIN_W-1:0]  lin;
			span_s = tns_pkg::SIZE_W'(span_of(tex_width));
			span_t = tns_pkg::SIZE_W'(span_of(tex_height));
			prod_s = PROD_W'(s[tns_pkg::FRAC_W-1:0]) * PROD_W'(span_s);
			prod_t = PROD_W'(t[tns_pkg::FRAC_W-1:0]) * PROD_W'(span_t);
			x = prod_s[PROD_W-1:tns_pkg::FRAC_W];
			y = prod_t[PROD_W-1:tns_pkg::FRAC_W];
			lin = tns_pkg::LIN_W'(x) + tns_pkg::LIN_W'(y) * tns_pkg::LIN_W'(tex_width);
			return lin[tns_pkg::ADDR_W-1:0];
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		// accepted input transaction: a load updates the store, a sample predicts a pixel
		function void note_item(logic kind, logic [135:0] data);
			logic [tns_pkg::TEXEL_W-1:0] texel;
			pixel_t                      px;
			if (kind == tns_pkg::KIND_LOAD) begin
				texel = {(has_alpha ? data[47:40] : tns_pkg::ALPHA_OPAQUE), data[39:32],
					data[31:24], data[23:16]};
				texels[data[15:0]] = texel;
			end else begin
				texel = texels[sample_addr(data[79:48], data[111:80])];
				px.dest = data[131:112];
				px.written = (texel[31:24] != 0);
				{px.alpha, px.blue, px.green, px.red} = px.written ? texel : '0;
				expected_pixels.push_back(px);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// accepted output transaction against the oldest expected pixel
		function void check_result(logic [55:0] data, logic user);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual tdata %0h tuser %0b",
					$time, data, user);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("out_dest_index", 32'(want.dest), 32'(data[19:0]));
			compare_field("out_red", 32'(want.red), 32'(data[27:20]));
			compare_field("out_green", 32'(want.green), 32'(data[35:28]));
			compare_field("out_blue", 32'(want.blue), 32'(data[43:36]));
			compare_field("out_alpha", 32'(want.alpha), 32'(data[51:44]));
			compare_field("written", 32'(want.written), 32'(user));
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [55:0]  m_tdata;
	logic         m_tuser;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	sample_scoreboard sb = new();

	// stimulus bookkeeping: entries ever loaded and the texels aimed at in this phase
	bit texel_loaded [tns_pkg::TEXELS];
	int phase_x[$];
	int phase_y[$];
	bit sender_burst = 1'b0;
	bit valid_held = 1'b0;
	bit hold_req = 1'b0;

	texture_nearest_sampler_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

	// transaction monitor on both stream sides
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_item(s_tuser, s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tuser);
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [7:0] draw_alpha();
		int r;
		r = $urandom_range(7);
		if (r == 0) return 8'd0;
		if (r == 1) return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	// result sink: random stalls, long ready stretches, and the long hold on request
	initial begin : result_sink
		int stall;
		int run;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = draw_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			run = ($urandom_range(9) == 0) ? $urandom_range(150, 50) : $urandom_range(8, 1);
			repeat (run) @(posedge clk);
		end
	end

	function automatic logic [135:0] pack_item(logic [15:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] a, logic [31:0] s, logic [31:0] t, logic [19:0] dest);
		return {4'b0, dest, t, s, a, b, g, r, idx};
	endfunction

	// coordinate whose fraction lands on column x of an axis scaled by span
	function automatic logic [31:0] coord_for(int x, int span);
		int          lo;
		int          hi;
		logic [31:0] whole;
		whole = $urandom;
		if (span == 0) return whole;
		lo = (x * 65536 + span - 1) / span;
		hi = ((x + 1) * 65536 + span - 1) / span - 1;
		if (hi > 65535) hi = 65535;
		return {whole[31:16], 16'($urandom_range(hi, lo))};
	endfunction

	task automatic pause_sender(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			valid_held = 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// offer one input transaction and hold it until accepted
	task automatic offer(input logic kind, input logic [135:0] data);
		s_tuser <= kind;
		s_tdata <= data;
		s_tvalid <= 1'b1;
		valid_held = 1'b1;
		do @(posedge clk); while (!s_tready);
		pause_sender(sender_burst ? 0 : draw_gap());
	endtask

	task automatic load_texel(input logic [15:0] idx, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		offer(tns_pkg::KIND_LOAD, pack_item(idx, r, g, b, a, $urandom, $urandom, 20'($urandom)));
		texel_loaded[idx] = 1'b1;
	endtask

	task automatic sample_at(input logic [31:0] s, input logic [31:0] t, input logic [19:0] dest);
		offer(tns_pkg::KIND_SAMPLE, pack_item(16'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), s, t, dest));
	endtask

	// wait until every expected pixel has come out and the pipeline has drained
	task automatic wait_idle();
		if (valid_held) pause_sender(1);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb setup and access phases, then psel and penable drop back to idle
	task automatic apb_access(input logic write, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// register write with read-back of the implemented bits
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] mask;
		apb_access(1'b1, idx, value, rd);
		sb.set_reg(idx, value);
		if (idx != REG_UNUSED) begin
			mask = (idx == tns_pkg::REG_HAS_ALPHA) ? 32'h1 : 32'h1FF;
			apb_access(1'b0, idx, 32'h0, rd);
			if ((rd & mask) !== (value & mask)) begin
				$display("%0t ns: register %0d read-back mismatch, expected %0h, actual %0h",
					$time, idx, value & mask, rd & mask);
				sb.errors++;
			end
		end
	endtask

	task automatic configure(input int w, input int h, input int ha);
		wait_idle();
		write_reg(tns_pkg::REG_TEX_WIDTH, w);
		write_reg(tns_pkg::REG_TEX_HEIGHT, h);
		write_reg(tns_pkg::REG_HAS_ALPHA, ha);
		write_reg(REG_UNUSED, $urandom);
	endtask

	// one random phase: aimed loads first, then a mix of loads and samples on loaded texels
	task automatic run_phase(input int w, input int h, input int ha, input int items,
			input bit burst, input int hold_at, input int drain_at);
		int          span_s;
		int          span_t;
		int          x;
		int          y;
		int          j;
		int          pick;
		bit          hit;
		logic [31:0] s;
		logic [31:0] t;
		configure(w, h, ha);
		sender_burst = burst;
		phase_x.delete();
		phase_y.delete();
		span_s = sb.span_of(tns_pkg::SIZE_W'(w));
		span_t = sb.span_of(tns_pkg::SIZE_W'(h));
		for (int i = 0; i < items; i++) begin
			if (i == hold_at) hold_req = 1'b1;
			if (i == drain_at) wait_idle();
			pick = (i < 10) ? 0 : $urandom_range(99);
			if (pick < 35) begin
				// load aimed at a texel the sampler can reach
				x = (span_s == 0) ? 0 : $urandom_range(span_s - 1);
				y = (span_t == 0) ? 0 : $urandom_range(span_t - 1);
				load_texel(16'(x + y * w), 8'($urandom), 8'($urandom), 8'($urandom),
					draw_alpha());
				phase_x.push_back(x);
				phase_y.push_back(y);
			end else if (pick < 45) begin
				load_texel(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					draw_alpha());
			end else begin
				// raw coordinates when they land on a loaded texel, else aim at one
				hit = 1'b0;
				for (int k = 0; k < 8 && !hit; k++) begin
					s = $urandom;
					t = $urandom;
					hit = texel_loaded[sb.sample_addr(s, t)];
				end
				if (!hit) begin
					if (phase_x.size() > 0) begin
						j = $urandom_range(phase_x.size() - 1);
						s = coord_for(phase_x[j], span_s);
						t = coord_for(phase_y[j], span_t);
					end else begin
						// zero fractions read texel zero, loaded at the start
						s = $urandom & 32'hFFFF_0000;
						t = $urandom & 32'hFFFF_0000;
					end
				end
				sample_at(s, t, 20'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset sizes: alpha forced opaque even with a zero alpha input, every read hits texel zero
		load_texel(16'd0, 8'h12, 8'h34, 8'h56, 8'h00);
		sample_at($urandom, $urandom, 20'($urandom));

		// directed: 4x3 texture with a transparent texel and channel extremes
		configure(4, 3, 1);
		for (int i = 0; i < 12; i++) begin
			if (i == 0) load_texel(16'(i), 8'h00, 8'h00, 8'h00, 8'hFF);
			else if (i == 5) load_texel(16'(i), 8'hA5, 8'h5A, 8'hC3, 8'h00);
			else if (i == 6) load_texel(16'(i), 8'hFF, 8'hFF, 8'hFF, 8'h01);
			else load_texel(16'(i), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom_range(255, 1)));
		end
		load_texel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		sample_at(coord_for(0, 3), coord_for(0, 2), 20'h00000);
		sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF);
		sample_at(32'h8000_0000, 32'h8000_0000, 20'($urandom));
		sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'($urandom));
		sample_at(coord_for(1, 3), coord_for(1, 2), 20'($urandom));
		sample_at(coord_for(2, 3), coord_for(0, 2), 20'($urandom));

		// random phases over sizes including zero, the largest and above range
		run_phase(1, 1, 0, 80, 1'b1, -1, -1);
		run_phase(5, 4, 1, 150, 1'b1, 60, -1);
		run_phase(0, 6, 1, 100, 1'b0, -1, -1);
		run_phase(9, 0, 0, 100, 1'b0, -1, -1);
		run_phase(256, 256, 1, 120, 1'b0, -1, -1);
		run_phase(511, 511, 1, 120, 1'b0, -1, -1);
		run_phase(2, 2, 0, 100, 1'b0, -1, 50);
		run_phase(16, 16, 1, 150, 1'b1, -1, -1);
		run_phase($urandom_range(12, 1), $urandom_range(12, 1), 0, 100, 1'b0, -1, -1);
		run_phase($urandom_range(12, 1), $urandom_range(12, 1), 1, 130, 1'b0, -1, -1);

		wait_idle();
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
